// File: src/mbse_pkg.sv
// Package: shared types, constants and functions of the multiboot stream encryptor.
`default_nettype none

package mbse_pkg;

    // Image size limits and field widths
    localparam int MAX_IMAGE_BYTES = 262144;
    localparam int MIN_IMAGE_BYTES = 512;
    localparam int HEADER_BYTES    = 'hC0;
    localparam int SIZE_W          = 19;
    localparam int WORD_W          = 32;
    localparam int CHECK_W         = 16;
    localparam int WORD_BYTES      = 4;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_TRANSFER_SIZE = '0;
    localparam logic [SIZE_W-1:0]     TRANSFER_SIZE_RESET = SIZE_W'(MIN_IMAGE_BYTES);

    // Scheme constants
    localparam logic [CHECK_W-1:0] CHECK_POLY   = 16'hA1C1;
    localparam logic [CHECK_W-1:0] CHECK_SEED   = 16'h15A0;
    localparam logic [WORD_W-1:0]  KEY_MULT     = 32'h6177614B;
    localparam logic [WORD_W-1:0]  CRYPT_MASK   = 32'h20796220;
    localparam logic [WORD_W-1:0]  SESSION_MASK = 32'h7365646F;
    localparam logic [WORD_W-1:0]  OFFSET_BIAS  = 32'h00000020 << 20;
    localparam logic [WORD_W-1:0]  OWN_KEY_BASE = 32'h00380000;
    localparam logic [WORD_W-1:0]  OWN_KEY_FILL = 32'h80808080;
    localparam logic [WORD_W-1:0]  OWN_TEXT_A   = 32'h6177614B;
    localparam logic [WORD_W-1:0]  OWN_TEXT_B   = 32'h6F646573;

    // Input operation codes
    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    // Result word kinds
    typedef enum logic [1:0] {
        KIND_OWN_KEY = 2'd0,
        KIND_PLAIN   = 2'd1,
        KIND_CRYPT   = 2'd2,
        KIND_CHECK   = 2'd3
    } word_kind_t;

    // Commands issued by the front
    typedef enum logic [1:0] {
        CMD_START,
        CMD_FAULT,
        CMD_HEADER,
        CMD_CRYPT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [WORD_W-1:0]  word;
        logic [SIZE_W-1:0]  offset;
        logic               last;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        word_kind_t        kind;
        logic              fault;
        logic              last;
    } out_t;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Round up to a multiple of 8 and clamp into the legal image range
    function automatic logic [SIZE_W-1:0] used_size(input logic [SIZE_W-1:0] ts);
        logic [SIZE_W:0] r;
        r = ({1'b0, ts} + (SIZE_W+1)'(7)) & ~((SIZE_W+1)'(7));
        if (r < (SIZE_W+1)'(MIN_IMAGE_BYTES))
            r = (SIZE_W+1)'(MIN_IMAGE_BYTES);
        else if (r > (SIZE_W+1)'(MAX_IMAGE_BYTES))
            r = (SIZE_W+1)'(MAX_IMAGE_BYTES);
        return r[SIZE_W-1:0];
    endfunction

    // Own key word as sent on the link (already in link byte order)
    function automatic logic [WORD_W-1:0] own_word(input logic [SIZE_W-1:0] s);
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] m;
        n = ({{(WORD_W-SIZE_W){1'b0}}, s} - WORD_W'(MIN_IMAGE_BYTES)) >> 3;
        a = ((n & 32'h00003F80) << 1) | ((n & 32'h00004000) << 2)
            | (n & 32'h0000007F) | OWN_KEY_BASE;
        t = ((a >> 8) + (a >> 16) + a) << 24;
        m = t | a | OWN_KEY_FILL;
        return m ^ (m[9] ? OWN_TEXT_B : OWN_TEXT_A);
    endfunction

    // 16-bit right-shift checksum over one word, LSB first
    function automatic logic [CHECK_W-1:0] shift_check(input logic [CHECK_W-1:0] c,
                                                       input logic [WORD_W-1:0] w);
        logic [CHECK_W-1:0] r;
        logic               fb;
        r = c;
        for (int k = 0; k < WORD_W; k++) begin
            fb = r[0] ^ w[k];
            r  = r >> 1;
            if (fb)
                r = r ^ CHECK_POLY;
        end
        return r;
    endfunction

    // Mix a word with the stepped key and the negated address term
    function automatic logic [WORD_W-1:0] encrypt(input logic [WORD_W-1:0] w,
                                                  input logic [WORD_W-1:0] key,
                                                  input logic [SIZE_W-1:0] off);
        logic [WORD_W-1:0] addr_term;
        addr_term = WORD_W'(0) - ({{(WORD_W-SIZE_W){1'b0}}, off} + OFFSET_BIAS);
        return w ^ key ^ addr_term ^ CRYPT_MASK;
    endfunction

endpackage

`default_nettype wire

// File: src/mbse_front.sv
// Front: accepts input transfers, tracks the session position and issues commands.
`default_nettype none

module mbse_front
    import mbse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_op,
    input  wire logic [WORD_W-1:0] in_session,
    input  wire logic [WORD_W-1:0] in_payload,
    input  wire logic [SIZE_W-1:0] size,
    input  wire logic              q_full,
    output logic                   push,
    output cmd_t                   cmd
);

    logic              active_reg, active_next;
    logic [SIZE_W-1:0] offset_reg, offset_next;
    logic [SIZE_W-1:0] offset_inc;

    assign in_ready   = !q_full;
    assign push       = in_valid && in_ready;
    assign offset_inc = offset_reg + SIZE_W'(WORD_BYTES);

    // Classify the item against the session position
    always_comb
    begin
        active_next = active_reg;
        offset_next = offset_reg;
        cmd.kind    = CMD_FAULT;
        cmd.word    = in_payload;
        cmd.offset  = offset_reg;
        cmd.last    = 1'b0;
        if (op_t'(in_op) == OP_START)
        begin
            cmd.kind    = CMD_START;
            cmd.word    = in_session;
            active_next = 1'b1;
            offset_next = '0;
        end
        else if (!active_reg || offset_reg >= size)
        begin
            cmd.kind = CMD_FAULT;
        end
        else if (offset_reg < SIZE_W'(HEADER_BYTES))
        begin
            cmd.kind    = CMD_HEADER;
            offset_next = offset_inc;
        end
        else
        begin
            cmd.kind    = CMD_CRYPT;
            offset_next = offset_inc;
            if (offset_inc == size)
            begin
                cmd.last    = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    // Advance the session state on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            offset_reg <= '0;
        end
        else if (push)
        begin
            active_reg <= active_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

// File: src/mbse_queue.sv
// Queue: short command FIFO between front and back.
`default_nettype none

module mbse_queue
    import mbse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      pop_data
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: src/mbse_back.sv
// Back: runs key generator and checksum, builds result words into the output register.
`default_nettype none

module mbse_back
    import mbse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire cmd_t              q_data,
    output logic                   pop,
    input  wire logic [SIZE_W-1:0] size,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_t                   out_item
);

    logic [WORD_W-1:0]  key_reg, key_next;
    logic [CHECK_W-1:0] check_reg, check_next;
    logic               pending_reg, pending_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;
    logic               slot_free;
    logic [WORD_W-1:0]  key_step;
    logic [WORD_W-1:0]  check_word;

    assign slot_free  = !out_valid_reg || out_ready;
    assign pop        = slot_free && !pending_reg && !q_empty;
    assign key_step   = key_reg * KEY_MULT + WORD_W'(1);
    assign check_word = {size[WORD_W-CHECK_W-1:0], check_reg};
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    // Execute the pending checksum word or the head command
    always_comb
    begin
        key_next       = key_reg;
        check_next     = check_reg;
        pending_next   = pending_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (slot_free)
        begin
            if (pending_reg)
            begin
                key_next       = key_step;
                pending_next   = 1'b0;
                out_valid_next = 1'b1;
                out_next.word  = encrypt(check_word, key_step, size);
                out_next.kind  = KIND_CHECK;
                out_next.fault = 1'b0;
                out_next.last  = 1'b1;
            end
            else if (!q_empty)
            begin
                out_valid_next = 1'b1;
                out_next.fault = 1'b0;
                out_next.last  = 1'b1;
                case (q_data.kind)
                    CMD_START:
                    begin
                        key_next      = swap32(q_data.word ^ SESSION_MASK);
                        check_next    = CHECK_SEED;
                        out_next.word = own_word(size);
                        out_next.kind = KIND_OWN_KEY;
                    end
                    CMD_HEADER:
                    begin
                        out_next.word = q_data.word;
                        out_next.kind = KIND_PLAIN;
                    end
                    CMD_CRYPT:
                    begin
                        check_next    = shift_check(check_reg, q_data.word);
                        key_next      = key_step;
                        out_next.word = encrypt(q_data.word, key_step, q_data.offset);
                        out_next.kind = KIND_CRYPT;
                        out_next.last = !q_data.last;
                        pending_next  = q_data.last;
                    end
                    default:
                    begin
                        out_next.word  = '0;
                        out_next.kind  = KIND_OWN_KEY;
                        out_next.fault = 1'b1;
                    end
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            check_reg     <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            check_reg     <= check_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// File: src/multiboot_stream_encryptor_unit.sv
// Top level: multiboot stream encryptor with stream channels and APB configuration.
//
//   Channel   Direction  Handshake              Content
//   s_*       in         s_tvalid / s_tready    start or payload item
//   m_*       out        m_tvalid / m_tready    result word, kind, fault, tlast
//   APB       in / out   psel+penable, pready   transfer_size at address 0
//
// One input item is taken per cycle while the two-entry command queue has room.
// Each item yields one result, held first in the queue and then in the output register;
// the final payload word also yields the checksum word, which takes the output register
// after that result. Output stalls back up into the queue and then into s_tready.
// rst_n clears the session, key, checksum, queue and output valid flag at once.
`default_nettype none

module multiboot_stream_encryptor_unit
    import mbse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [63:0]           s_tdata,   // [31:0] session_word, [63:32] payload_word
    input  wire logic                  s_tuser,   // [0] operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [31:0] out_word
    output logic [2:0]                 m_tuser,   // [1:0] word_kind, [2] fault
    output logic                       m_tlast,   // last_of_run
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [SIZE_W-1:0] transfer_size_reg;
    logic [SIZE_W-1:0] size_used;
    logic              cfg_write;
    logic              q_push, q_pop, q_full, q_empty;
    cmd_t              q_in, q_out;
    out_t              result;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_TRANSFER_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            transfer_size_reg <= TRANSFER_SIZE_RESET;
        else if (cfg_write)
            transfer_size_reg <= pwdata[SIZE_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_TRANSFER_SIZE)
            prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, transfer_size_reg};
    end

    assign size_used = used_size(transfer_size_reg);

    mbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_session (s_tdata[31:0]),
        .in_payload (s_tdata[63:32]),
        .size       (size_used),
        .q_full     (q_full),
        .push       (q_push),
        .cmd        (q_in)
    );

    mbse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    mbse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .pop       (q_pop),
        .size      (size_used),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (result)
    );

    // Drive the result channel
    assign m_tdata = result.word;
    assign m_tuser = {result.fault, result.kind};
    assign m_tlast = result.last;

endmodule

`default_nettype wire

// File: src/mbse_checker.sv
// Checker: port-level assertions for the multiboot stream encryptor, bound to the top level.
`default_nettype none

module mbse_checker
    import mbse_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // Hold a stalled result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Fault result carries a zero word of kind own key and ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata == '0 && m_tuser[1:0] == KIND_OWN_KEY && m_tlast)
        else $error("malformed fault result");

    // Checksum word always ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_CHECK |-> m_tlast && !m_tuser[2])
        else $error("checksum word without tlast");

    // Final payload word is followed directly by the checksum word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[1:0] == KIND_CRYPT && !m_tlast
        |=> m_tvalid && m_tuser[1:0] == KIND_CHECK)
        else $error("checksum word missing after final payload");

endmodule

bind multiboot_stream_encryptor_unit mbse_checker u_mbse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
